// ===== rtl/flv_tag_demux_core_assert.svh =====
// ----------------------------------------------------------------------------
// FLV tag demux assertion macros
// Concurrent check wrappers; compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef FLV_TAG_DEMUX_CORE_ASSERT_SVH
`define FLV_TAG_DEMUX_CORE_ASSERT_SVH

`ifndef SYNTH
// cons must hold in the cycle after ante
`define FLVD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
// cons must hold in the same cycle as ante
`define FLVD_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// expr must never be true
`define FLVD_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define FLVD_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`define FLVD_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define FLVD_ASSERT_NEVER(lbl, clk, rst, expr, msg)
`endif

`endif

// ===== rtl/flvd_pkg.sv =====
// ----------------------------------------------------------------------------
// flvd_pkg
// Shared types and constants of the FLV tag demux.
// ----------------------------------------------------------------------------
`default_nettype none

package flvd_pkg;

  localparam int PAYLOAD_OFFSET_W = 40;
  localparam int TS_MS_W          = 34;
  localparam int TS_US_W          = 43;
  localparam int US_PER_MS        = 1000;

  typedef enum logic [1:0] {
    KIND_MEDIA  = 2'd0,
    KIND_CONFIG = 2'd1,
    KIND_HEADER = 2'd2,
    KIND_SHORT  = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t                       kind;
    logic                        track;
    logic [PAYLOAD_OFFSET_W-1:0] payload_offset;
    logic [23:0]                 payload_size;
    logic signed [TS_MS_W-1:0]   ts_ms;
    logic [3:0]                  codec_id;
    logic [3:0]                  frame_type;
    logic [7:0]                  packet_type;
    logic [7:0]                  version;
    logic                        has_audio;
    logic                        has_video;
  } rec_t;

endpackage

`default_nettype wire

// ===== rtl/flv_tag_demux_core.sv =====
// ----------------------------------------------------------------------------
// flv_tag_demux_core
// FLV container demultiplexer: byte stream in, tag records out.
// ----------------------------------------------------------------------------
// Accepts one FLV file byte per clock and never stalls on its own; every
// byte passes combinationally through the parser state into a record
// register, and records reach the output through that register and then
// the register after the ms-to-us multiplier.
// in_ready drops only when both record stages hold requests that out_ready
// has not taken. Assert file_start on byte 0 of each file.
`default_nettype none

module flv_tag_demux_core import flvd_pkg::*; #(
  parameter int OFFSET_BITS = 40
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  file_byte,
  input  logic                        file_start,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  record_kind,
  output logic                        track,
  output logic [PAYLOAD_OFFSET_W-1:0] payload_offset,
  output logic [23:0]                 payload_size,
  output logic signed [TS_US_W-1:0]   timestamp_us,
  output logic [3:0]                  codec_id,
  output logic [3:0]                  frame_type,
  output logic [7:0]                  packet_type,
  output logic [7:0]                  version,
  output logic                        has_audio,
  output logic                        has_video
);

  logic rec_valid;
  logic rec_ready;
  rec_t rec;

  flvd_parser #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .file_byte (file_byte),
    .file_start(file_start),
    .rec_valid (rec_valid),
    .rec       (rec),
    .rec_ready (rec_ready)
  );

  flvd_scale u_scale (
    .clk           (clk),
    .rst           (rst),
    .rec_valid     (rec_valid),
    .rec           (rec),
    .rec_ready     (rec_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .record_kind   (record_kind),
    .track         (track),
    .payload_offset(payload_offset),
    .payload_size  (payload_size),
    .timestamp_us  (timestamp_us),
    .codec_id      (codec_id),
    .frame_type    (frame_type),
    .packet_type   (packet_type),
    .version       (version),
    .has_audio     (has_audio),
    .has_video     (has_video)
  );

endmodule

`default_nettype wire

// ===== rtl/flvd_parser.sv =====
// ----------------------------------------------------------------------------
// flvd_parser
// Byte-wise FLV parser; registers the header and announced A/V tags.
// ----------------------------------------------------------------------------
`default_nettype none
`include "flv_tag_demux_core_assert.svh"

module flvd_parser import flvd_pkg::*; #(
  parameter int OFFSET_BITS = 40
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] file_byte,
  input  logic       file_start,
  output logic       rec_valid,
  output rec_t       rec,
  input  logic       rec_ready
);

  localparam logic [7:0] TAG_AUDIO = 8'h08;
  localparam logic [7:0] TAG_VIDEO = 8'h09;
  localparam logic [3:0] CODEC_AAC = 4'd10;
  localparam logic [3:0] CODEC_AVC = 4'd7;
  localparam int WideW = (OFFSET_BITS > PAYLOAD_OFFSET_W) ? OFFSET_BITS : PAYLOAD_OFFSET_W;

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_PREV   = 4'b0010,
    PH_TAGHDR = 4'b0100,
    PH_DATA   = 4'b1000
  } phase_t;

  phase_t                 phase, e_phase, phase_next;
  logic [23:0]            cnt, e_cnt, cnt_next;
  logic [7:0]             tag_kind, e_tag_kind, tag_kind_next;
  logic [23:0]            size, e_size, size_next;
  logic [31:0]            time_ms, e_time_ms, time_ms_next;
  logic [7:0]             first, e_first, first_next;
  logic [7:0]             second, e_second, second_next;
  logic [23:0]            cto, e_cto, cto_next;
  logic                   audio_present, e_audio_present, audio_present_next;
  logic                   video_present, e_video_present, video_present_next;
  logic                   audio_is_aac, e_audio_is_aac, audio_is_aac_next;
  logic                   video_is_avc, e_video_is_avc, video_is_avc_next;
  logic [OFFSET_BITS-1:0] pos, pos_next;
  logic [OFFSET_BITS-1:0] data_start, e_data_start, data_start_next;

  logic                   acc;
  logic                   hdr_fire;
  logic                   fin;
  logic [OFFSET_BITS-1:0] start_pos;

  logic                   is_a, is_v, coded, add_cto, fire;
  logic [2:0]             need, skip;
  logic [OFFSET_BITS-1:0] off_pos;
  logic [WideW-1:0]       off_wide;
  rec_t                   rec_next;

  assign acc = in_valid && in_ready;
  assign in_ready = !rec_valid || rec_ready;

  // file_start restarts from the reset state before this byte is parsed
  always_comb begin
    if (file_start) begin
      e_phase         = PH_HEADER;
      e_cnt           = '0;
      e_tag_kind      = '0;
      e_size          = '0;
      e_time_ms       = '0;
      e_first         = '0;
      e_second        = '0;
      e_cto           = '0;
      e_audio_present = 1'b0;
      e_video_present = 1'b0;
      e_audio_is_aac  = 1'b0;
      e_video_is_avc  = 1'b0;
      e_data_start    = '0;
      pos_next        = OFFSET_BITS'(1);
    end else begin
      e_phase         = phase;
      e_cnt           = cnt;
      e_tag_kind      = tag_kind;
      e_size          = size;
      e_time_ms       = time_ms;
      e_first         = first;
      e_second        = second;
      e_cto           = cto;
      e_audio_present = audio_present;
      e_video_present = video_present;
      e_audio_is_aac  = audio_is_aac;
      e_video_is_avc  = video_is_avc;
      e_data_start    = data_start;
      pos_next        = pos + OFFSET_BITS'(1);
    end
  end

  always_comb begin
    phase_next         = e_phase;
    cnt_next           = e_cnt;
    tag_kind_next      = e_tag_kind;
    size_next          = e_size;
    time_ms_next       = e_time_ms;
    first_next         = e_first;
    second_next        = e_second;
    cto_next           = e_cto;
    audio_present_next = e_audio_present;
    video_present_next = e_video_present;
    audio_is_aac_next  = e_audio_is_aac;
    video_is_avc_next  = e_video_is_avc;
    data_start_next    = e_data_start;
    hdr_fire           = 1'b0;
    fin                = 1'b0;
    start_pos          = e_data_start;
    unique case (e_phase)
      PH_HEADER: begin
        if (e_cnt == 24'd3) tag_kind_next = file_byte;
        if (e_cnt == 24'd4) begin
          audio_present_next = file_byte[2];
          video_present_next = file_byte[0];
        end
        if (e_cnt >= 24'd8) begin
          hdr_fire      = 1'b1;
          tag_kind_next = '0;
          phase_next    = PH_PREV;
          cnt_next      = '0;
        end else begin
          cnt_next = e_cnt + 24'd1;
        end
      end
      PH_PREV: begin
        if (e_cnt >= 24'd3) begin
          phase_next = PH_TAGHDR;
          cnt_next   = '0;
        end else begin
          cnt_next = e_cnt + 24'd1;
        end
      end
      PH_TAGHDR: begin
        if (e_cnt == 24'd0) begin
          tag_kind_next = file_byte;
          size_next     = '0;
          time_ms_next  = '0;
          first_next    = '0;
          second_next   = '0;
          cto_next      = '0;
          if (file_byte == TAG_AUDIO) audio_is_aac_next = 1'b0;
          if (file_byte == TAG_VIDEO) video_is_avc_next = 1'b0;
        end else if (e_cnt <= 24'd3) begin
          size_next = {e_size[15:0], file_byte};
        end else if (e_cnt <= 24'd6) begin
          time_ms_next = {8'h00, e_time_ms[15:0], file_byte};
        end else if (e_cnt == 24'd7) begin
          time_ms_next = {e_time_ms[31:24] | file_byte, e_time_ms[23:0]};
        end
        if (e_cnt >= 24'd10) begin
          cnt_next        = '0;
          data_start_next = pos_next;
          if (e_size == 24'd0) begin
            fin        = 1'b1;
            start_pos  = pos_next;
            phase_next = PH_PREV;
          end else begin
            phase_next = PH_DATA;
          end
        end else begin
          cnt_next = e_cnt + 24'd1;
        end
      end
      PH_DATA: begin
        if (e_cnt == 24'd0) begin
          first_next = file_byte;
          if (e_tag_kind == TAG_AUDIO) audio_is_aac_next = (file_byte[7:4] == CODEC_AAC);
          if (e_tag_kind == TAG_VIDEO) video_is_avc_next = (file_byte[3:0] == CODEC_AVC);
        end else if (e_cnt == 24'd1) begin
          second_next = file_byte;
        end else if (e_cnt == 24'd2) begin
          cto_next[23:16] = file_byte;
        end else if (e_cnt == 24'd3) begin
          cto_next[15:8] = file_byte;
        end else if (e_cnt == 24'd4) begin
          cto_next[7:0] = file_byte;
        end
        if (({1'b0, e_cnt} + 25'd1) >= {1'b0, e_size}) begin
          fin        = 1'b1;
          phase_next = PH_PREV;
          cnt_next   = '0;
        end else begin
          cnt_next = e_cnt + 24'd1;
        end
      end
      default: begin
        phase_next = PH_TAGHDR;
        cnt_next   = '0;
      end
    endcase
  end

  // record build
  always_comb begin
    is_a    = (tag_kind_next == TAG_AUDIO) && audio_present_next;
    is_v    = (tag_kind_next == TAG_VIDEO) && video_present_next;
    coded   = is_v ? video_is_avc_next : audio_is_aac_next;
    need    = coded ? (is_v ? 3'd5 : 3'd2) : 3'd1;
    add_cto = 1'b0;
    rec_next = '0;
    if (hdr_fire) begin
      rec_next.kind      = KIND_HEADER;
      rec_next.version   = e_tag_kind;
      rec_next.has_audio = e_audio_present;
      rec_next.has_video = e_video_present;
      skip               = 3'd0;
    end else begin
      rec_next.track      = !is_a;
      rec_next.codec_id   = is_v ? first_next[3:0] : first_next[7:4];
      rec_next.frame_type = is_v ? first_next[7:4] : 4'd0;
      if (size_next < {21'd0, need}) begin
        rec_next.kind = KIND_SHORT;
        skip          = 3'd0;
      end else if (coded) begin
        rec_next.packet_type = second_next;
        rec_next.kind        = (second_next == 8'd0) ? KIND_CONFIG : KIND_MEDIA;
        skip                 = need;
        add_cto              = is_v && (second_next == 8'd1);
      end else begin
        rec_next.kind = KIND_MEDIA;
        skip          = 3'd1;
      end
    end
    off_pos  = start_pos + OFFSET_BITS'(skip);
    off_wide = WideW'(off_pos);
    if (!hdr_fire) begin
      rec_next.payload_offset = off_wide[PAYLOAD_OFFSET_W-1:0];
      rec_next.payload_size   = size_next - {21'd0, skip};
      rec_next.ts_ms          = {2'b00, time_ms_next}
                                + (add_cto ? {{10{cto_next[23]}}, cto_next} : {TS_MS_W{1'b0}});
    end
    fire = hdr_fire || (fin && (is_a || is_v));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HEADER;
      cnt           <= '0;
      tag_kind      <= '0;
      size          <= '0;
      time_ms       <= '0;
      first         <= '0;
      second        <= '0;
      cto           <= '0;
      audio_present <= 1'b0;
      video_present <= 1'b0;
      audio_is_aac  <= 1'b0;
      video_is_avc  <= 1'b0;
      pos           <= '0;
      data_start    <= '0;
      rec_valid     <= 1'b0;
    end else begin
      if (acc) begin
        phase         <= phase_next;
        cnt           <= cnt_next;
        tag_kind      <= tag_kind_next;
        size          <= size_next;
        time_ms       <= time_ms_next;
        first         <= first_next;
        second        <= second_next;
        cto           <= cto_next;
        audio_present <= audio_present_next;
        video_present <= video_present_next;
        audio_is_aac  <= audio_is_aac_next;
        video_is_avc  <= video_is_avc_next;
        pos           <= pos_next;
        data_start    <= data_start_next;
      end
      if (in_ready) rec_valid <= acc && fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) rec <= rec_next;
  end

  `FLVD_ASSERT_NEVER(a_hdr_cnt_range, clk, rst, (phase == PH_HEADER) && (cnt > 24'd8), "header count out of range")
  `FLVD_ASSERT_NEXT(a_prev_to_taghdr, clk, rst, acc && !file_start && (phase == PH_PREV) && (cnt == 24'd3), (phase == PH_TAGHDR) && (cnt == 24'd0), "prev-size skip did not end")
  `FLVD_ASSERT_NEXT(a_restart, clk, rst, acc && file_start, (phase == PH_HEADER) && (cnt == 24'd1) && (pos == OFFSET_BITS'(1)), "file restart not taken")

endmodule

`default_nettype wire

// ===== rtl/flvd_scale.sv =====
// ----------------------------------------------------------------------------
// flvd_scale
// Output register stage; converts millisecond time to microseconds.
// ----------------------------------------------------------------------------
`default_nettype none
`include "flv_tag_demux_core_assert.svh"

module flvd_scale import flvd_pkg::*; (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        rec_valid,
  input  rec_t                        rec,
  output logic                        rec_ready,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  record_kind,
  output logic                        track,
  output logic [PAYLOAD_OFFSET_W-1:0] payload_offset,
  output logic [23:0]                 payload_size,
  output logic signed [TS_US_W-1:0]   timestamp_us,
  output logic [3:0]                  codec_id,
  output logic [3:0]                  frame_type,
  output logic [7:0]                  packet_type,
  output logic [7:0]                  version,
  output logic                        has_audio,
  output logic                        has_video
);

  localparam int ProdW = TS_US_W + 1;

  logic [ProdW-1:0] prod;

  assign rec_ready = !out_valid || out_ready;
  assign prod = {{(ProdW-TS_MS_W){rec.ts_ms[TS_MS_W-1]}}, rec.ts_ms} * ProdW'(US_PER_MS);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (rec_ready) begin
      out_valid <= rec_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rec_ready) begin
      record_kind    <= rec.kind;
      track          <= rec.track;
      payload_offset <= rec.payload_offset;
      payload_size   <= rec.payload_size;
      timestamp_us   <= prod[TS_US_W-1:0];
      codec_id       <= rec.codec_id;
      frame_type     <= rec.frame_type;
      packet_type    <= rec.packet_type;
      version        <= rec.version;
      has_audio      <= rec.has_audio;
      has_video      <= rec.has_video;
    end
  end

  `FLVD_ASSERT_NEXT(a_load, clk, rst, rec_valid && rec_ready, out_valid, "request lost at output stage")
  `FLVD_ASSERT_NEXT(a_bubble, clk, rst, !rec_valid && rec_ready, !out_valid, "request invented at output stage")
  `FLVD_ASSERT_NEXT(a_hdr_zero_ts, clk, rst, rec_valid && rec_ready && (rec.kind == KIND_HEADER), (timestamp_us == '0) && (record_kind == KIND_HEADER), "header record not clean")

endmodule

`default_nettype wire

// ===== verif/flv_tag_demux_core_tb.sv =====
// ----------------------------------------------------------------------------
// flv_tag_demux_core_tb
// Feeds FLV byte streams through the demux and checks every tag record.
// Directed files cover the AAC/AVC header forms, short tags, signed CTO,
// silent tracks and cut-off tags. Random files follow them, with backpressure
// on both channels. A parser model in the scoreboard predicts each record.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module flv_tag_demux_core_tb;
  import flvd_pkg::*;

  localparam logic [7:0] TAG_AUDIO   = 8'h08;
  localparam logic [7:0] TAG_VIDEO   = 8'h09;
  localparam logic [7:0] TAG_SCRIPT  = 8'h12;
  localparam logic [3:0] CODEC_AAC   = 4'd10;
  localparam logic [3:0] CODEC_AVC   = 4'd7;
  localparam logic [7:0] PKT_SEQ_HDR = 8'd0;
  localparam logic [7:0] PKT_NALU    = 8'd1;
  localparam int         CALM_TAIL   = 150;

  typedef enum int {PH_FILE_HDR, PH_SKIP_PREV, PH_TAG_HDR, PH_TAG_DATA} parse_phase_e;

  typedef struct {
    kind_t                       kind;
    logic                        track;
    logic [PAYLOAD_OFFSET_W-1:0] offset;
    logic [23:0]                 size;
    logic signed [TS_US_W-1:0]   ts_us;
    logic [3:0]                  codec;
    logic [3:0]                  frame;
    logic [7:0]                  ptype;
    logic [7:0]                  version;
    logic                        has_a;
    logic                        has_v;
  } flv_rec_t;

  typedef struct {
    logic [7:0] b;
    logic       s;
  } flv_byte_t;

  class flv_record_board;
    flv_rec_t     pending_records[$];
    logic [39:0]  pos;
    parse_phase_e phase;
    int unsigned  cnt;
    logic [7:0]   tag_type;
    logic [23:0]  dsize;
    logic [31:0]  tms;
    logic [39:0]  hdr5;
    bit           a_on, v_on, aac, avc;
    int           errors;
    int           checked;
    int           kind_seen[4];

    function new();
      clear();
    endfunction

    function void clear();
      pos = '0;
      phase = PH_FILE_HDR;
      cnt = 0;
      tag_type = '0;
      dsize = '0;
      tms = '0;
      hdr5 = '0;
      a_on = 0;
      v_on = 0;
      aac = 0;
      avc = 0;
    endfunction

    function void add_record(flv_rec_t r);
      pending_records.insert(pending_records.size(), r);
    endfunction

    function flv_rec_t blank_rec();
      flv_rec_t r;
      r.kind = KIND_MEDIA;
      r.track = 0;
      r.offset = '0;
      r.size = '0;
      r.ts_us = '0;
      r.codec = '0;
      r.frame = '0;
      r.ptype = '0;
      r.version = '0;
      r.has_a = 0;
      r.has_v = 0;
      return r;
    endfunction

    function void close_tag(logic [39:0] here);
      flv_rec_t    r;
      bit          vid, coded;
      logic [7:0]  first, second;
      logic [23:0] cto;
      int unsigned need, skip;
      logic [39:0] start;
      longint      ts;
      if (tag_type == TAG_AUDIO && a_on) vid = 0;
      else if (tag_type == TAG_VIDEO && v_on) vid = 1;
      else return;
      first = hdr5[39:32];
      second = hdr5[31:24];
      cto = hdr5[23:0];
      r = blank_rec();
      r.track = vid;
      r.codec = vid ? first[3:0] : first[7:4];
      r.frame = vid ? first[7:4] : 4'h0;
      coded = vid ? avc : aac;
      need = coded ? (vid ? 5 : 2) : 1;
      ts = longint'(tms) * 1000;
      start = here + 40'd1 - 40'(dsize);
      if (dsize < need) begin
        r.kind = KIND_SHORT;
        skip = 0;
      end else if (coded) begin
        r.ptype = second;
        r.kind = (second == PKT_SEQ_HDR) ? KIND_CONFIG : KIND_MEDIA;
        skip = need;
        if (vid && second == PKT_NALU) ts += longint'($signed(cto)) * 1000;
      end else begin
        r.kind = KIND_MEDIA;
        skip = 1;
      end
      r.offset = start + 40'(skip);
      r.size = dsize - 24'(skip);
      r.ts_us = ts[42:0];
      add_record(r);
    endfunction

    // one accepted request: advance the parser, queue any record it closes
    function void parse_byte(logic [7:0] b, logic s);
      flv_rec_t    r;
      logic [39:0] here;
      if (s) clear();
      here = pos;
      case (phase)
        PH_FILE_HDR: begin
          if (cnt == 3) tag_type = b;
          if (cnt == 4) begin
            a_on = b[2];
            v_on = b[0];
          end
          if (cnt >= 8) begin
            r = blank_rec();
            r.kind = KIND_HEADER;
            r.version = tag_type;
            r.has_a = a_on;
            r.has_v = v_on;
            add_record(r);
            tag_type = '0;
            phase = PH_SKIP_PREV;
            cnt = 0;
          end else cnt++;
        end
        PH_SKIP_PREV: begin
          if (cnt >= 3) begin
            phase = PH_TAG_HDR;
            cnt = 0;
          end else cnt++;
        end
        PH_TAG_HDR: begin
          if (cnt == 0) begin
            tag_type = b;
            dsize = '0;
            tms = '0;
            hdr5 = '0;
            if (b == TAG_AUDIO) aac = 0;
            if (b == TAG_VIDEO) avc = 0;
          end else if (cnt <= 3) dsize = {dsize[15:0], b};
          else if (cnt <= 6) tms = {8'h00, tms[15:0], b};
          else if (cnt == 7) tms[31:24] = b;
          if (cnt >= 10) begin
            cnt = 0;
            if (dsize == 0) begin
              close_tag(here);
              phase = PH_SKIP_PREV;
            end else phase = PH_TAG_DATA;
          end else cnt++;
        end
        default: begin
          if (cnt == 0) begin
            hdr5[39:32] = b;
            if (tag_type == TAG_AUDIO) aac = (b[7:4] == CODEC_AAC);
            if (tag_type == TAG_VIDEO) avc = (b[3:0] == CODEC_AVC);
          end else if (cnt <= 4) hdr5[(4 - cnt) * 8 +: 8] = b;
          if (cnt + 1 >= dsize) begin
            close_tag(here);
            phase = PH_SKIP_PREV;
            cnt = 0;
          end else cnt++;
        end
      endcase
      pos = here + 40'd1;
    endfunction

    function void diff(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t ns: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, want, got);
      end
    endfunction

    function void check_record(flv_rec_t got);
      flv_rec_t want;
      if (pending_records.size() == 0) begin
        errors++;
        $display("%0t ns: record with none expected, expected none actual kind %0d",
                 $time, got.kind);
        return;
      end
      want = pending_records.pop_front();
      checked++;
      kind_seen[want.kind]++;
      diff("record_kind", want.kind, got.kind);
      diff("track", want.track, got.track);
      diff("payload_offset", want.offset, got.offset);
      diff("payload_size", want.size, got.size);
      diff("timestamp_us", want.ts_us, got.ts_us);
      diff("codec_id", want.codec, got.codec);
      diff("frame_type", want.frame, got.frame);
      diff("packet_type", want.ptype, got.ptype);
      diff("version", want.version, got.version);
      diff("has_audio", want.has_a, got.has_a);
      diff("has_video", want.has_v, got.has_v);
    endfunction
  endclass

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [7:0]                  file_byte = 8'h00;
  logic                        file_start = 1'b0;
  logic                        out_valid;
  logic                        out_ready = 1'b1;
  logic [1:0]                  record_kind;
  logic                        track;
  logic [PAYLOAD_OFFSET_W-1:0] payload_offset;
  logic [23:0]                 payload_size;
  logic signed [TS_US_W-1:0]   timestamp_us;
  logic [3:0]                  codec_id;
  logic [3:0]                  frame_type;
  logic [7:0]                  packet_type;
  logic [7:0]                  version;
  logic                        has_audio;
  logic                        has_video;

  flv_record_board sb = new();
  flv_byte_t       stim[$];
  int              num_files;
  int              num_random_files;
  bit              calm;
  int unsigned     cycles;
  int unsigned     cycle_limit = 32'd2_000_000;

  flv_tag_demux_core u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .file_byte      (file_byte),
    .file_start     (file_start),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .record_kind    (record_kind),
    .track          (track),
    .payload_offset (payload_offset),
    .payload_size   (payload_size),
    .timestamp_us   (timestamp_us),
    .codec_id       (codec_id),
    .frame_type     (frame_type),
    .packet_type    (packet_type),
    .version        (version),
    .has_audio      (has_audio),
    .has_video      (has_video)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > cycle_limit) begin
      $display("timeout after %0d cycles, %0d records outstanding", cycles,
               sb.pending_records.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) sb.parse_byte(file_byte, file_start);
  end

  always @(posedge clk) begin
    flv_rec_t got;
    if (!rst && out_valid && out_ready) begin
      got.kind = kind_t'(record_kind);
      got.track = track;
      got.offset = payload_offset;
      got.size = payload_size;
      got.ts_us = timestamp_us;
      got.codec = codec_id;
      got.frame = frame_type;
      got.ptype = packet_type;
      got.version = version;
      got.has_a = has_audio;
      got.has_v = has_video;
      sb.check_record(got);
    end
  end

  // receiver stalls
  initial begin
    forever begin
      repeat ($urandom_range(1, 20)) @(posedge clk);
      if (!calm && $urandom_range(0, 99) < 40) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_ready <= 1'b1;
      end
    end
  end

  function void add_byte(logic [7:0] b, logic s);
    flv_byte_t item;
    item.b = b;
    item.s = s;
    stim.insert(stim.size(), item);
    if (s) num_files++;
  endfunction

  function void add_file_header(logic [7:0] ver, logic [7:0] flags, bit start, bit junk);
    logic [7:0] sig[3];
    int         i;
    sig = '{8'h46, 8'h4C, 8'h56};
    for (i = 0; i < 3; i++) add_byte(junk ? 8'($urandom) : sig[i], (i == 0) ? start : 1'b0);
    add_byte(ver, 1'b0);
    add_byte(flags, 1'b0);
    for (i = 0; i < 8; i++)
      add_byte(junk ? 8'($urandom) : ((i == 3) ? 8'h09 : 8'h00), 1'b0);
  endfunction

  // keep < 0 emits the whole tag; otherwise only its first keep bytes
  function void add_tag(logic [7:0] ttype, logic [23:0] dsize, logic [31:0] ms,
                        logic [7:0] d0, logic [7:0] d1, logic [23:0] cto, int keep);
    logic [7:0]  hdr[11];
    logic [31:0] prev_size;
    logic [7:0]  v;
    int          total, n, i, j;
    hdr = '{ttype, dsize[23:16], dsize[15:8], dsize[7:0], ms[23:16], ms[15:8], ms[7:0],
            ms[31:24], 8'($urandom), 8'($urandom), 8'($urandom)};
    prev_size = 32'(dsize) + 32'd11;
    total = 15 + int'(dsize);
    n = (keep >= 0 && keep < total) ? keep : total;
    for (i = 0; i < n; i++) begin
      j = i - 11;
      if (i < 11) v = hdr[i];
      else if (j < int'(dsize))
        v = (j == 0) ? d0 : (j == 1) ? d1 : (j <= 4) ? cto[(4 - j) * 8 +: 8] : 8'($urandom);
      else v = prev_size[(3 - (j - int'(dsize))) * 8 +: 8];
      add_byte(v, 1'b0);
    end
  endfunction

  // returns 1 when the tag was cut short and the file should end
  function bit add_random_tag();
    int          p;
    logic [7:0]  ttype, d0, d1;
    logic [31:0] ms;
    int          need, size, keep;
    p = $urandom_range(0, 99);
    d0 = 8'($urandom);
    need = 1;
    if (p < 40) begin
      ttype = TAG_AUDIO;
      if ($urandom_range(0, 1)) d0[7:4] = CODEC_AAC;
      if (d0[7:4] == CODEC_AAC) need = 2;
    end else if (p < 80) begin
      ttype = TAG_VIDEO;
      if ($urandom_range(0, 1)) d0[3:0] = CODEC_AVC;
      if (d0[3:0] == CODEC_AVC) need = 5;
    end else if (p < 90) ttype = TAG_SCRIPT;
    else ttype = 8'($urandom);
    p = $urandom_range(0, 99);
    d1 = (p < 30) ? PKT_SEQ_HDR : (p < 80) ? PKT_NALU : 8'($urandom);
    p = $urandom_range(0, 99);
    if (p < 10) size = need - $urandom_range(0, 1);
    else if (p < 70) size = $urandom_range(0, 12);
    else if (p < 97) size = $urandom_range(13, 48);
    else size = $urandom_range(100, 300);
    p = $urandom_range(0, 99);
    ms = (p < 10) ? 32'd0 : (p < 20) ? 32'hFFFF_FFFF : $urandom;
    keep = -1;
    if ($urandom_range(0, 99) < 5) begin
      keep = $urandom_range(1, 14 + size);
      if ($urandom_range(0, 3) == 0) size = $urandom_range(1 << 16, 24'hFF_FFFF);
    end
    add_tag(ttype, 24'(size), ms, d0, d1, 24'($urandom), keep);
    return keep >= 0;
  endfunction

  function void build_stimulus();
    int         ntags, t, p;
    logic [7:0] flags;
    // both tracks: every codec header form, short and empty tags, CTO extremes
    add_file_header(8'hFF, 8'h05, 1'b1, 1'b0);
    add_tag(TAG_AUDIO, 4, 32'd0, 8'hAF, PKT_SEQ_HDR, 24'h0, -1);
    add_tag(TAG_AUDIO, 6, 32'hFFFF_FFFF, 8'hAE, PKT_NALU, 24'h0, -1);
    add_tag(TAG_AUDIO, 1, 32'h0000_1234, 8'hA3, 8'h00, 24'h0, -1);
    add_tag(TAG_AUDIO, 3, 32'h0100_0000, 8'h2F, 8'h55, 24'h0, -1);
    add_tag(TAG_AUDIO, 0, 32'd1, 8'h00, 8'h00, 24'h0, -1);
    add_tag(TAG_VIDEO, 9, 32'd40, 8'h17, PKT_SEQ_HDR, 24'h0, -1);
    add_tag(TAG_VIDEO, 7, 32'd0, 8'h27, PKT_NALU, 24'h80_0000, -1);
    add_tag(TAG_VIDEO, 5, 32'hFFFF_FFFF, 8'hF7, PKT_NALU, 24'h7F_FFFF, -1);
    add_tag(TAG_VIDEO, 5, 32'd100, 8'h17, 8'h02, 24'h00_0010, -1);
    add_tag(TAG_VIDEO, 4, 32'd7, 8'h27, PKT_NALU, 24'h0, -1);
    add_tag(TAG_VIDEO, 2, 32'd8, 8'h22, 8'hFF, 24'h0, -1);
    add_tag(TAG_SCRIPT, 3, 32'd9, 8'h02, 8'h00, 24'h0, -1);
    add_tag(8'hFF, 2, 32'd9, 8'hFF, 8'hFF, 24'h0, -1);
    add_tag(TAG_VIDEO, 0, 32'd10, 8'h00, 8'h00, 24'h0, -1);
    // huge tag cut off by a restart
    add_tag(TAG_VIDEO, 24'hFF_FFFF, 32'd5, 8'h17, PKT_NALU, 24'h0, 20);
    // no tracks announced, junk signature
    add_file_header(8'h00, 8'h00, 1'b1, 1'b1);
    add_tag(TAG_AUDIO, 3, 32'd1, 8'hAF, PKT_NALU, 24'h0, -1);
    add_tag(TAG_VIDEO, 6, 32'd1, 8'h17, PKT_NALU, 24'h0, -1);
    // audio only, then video only with the other flag bits set
    add_file_header(8'h01, 8'h04, 1'b1, 1'b0);
    add_tag(TAG_VIDEO, 6, 32'd2, 8'h17, PKT_NALU, 24'h0, -1);
    add_tag(TAG_AUDIO, 5, 32'd3, 8'hAF, PKT_NALU, 24'h0, -1);
    add_file_header(8'h7E, 8'hFB, 1'b1, 1'b0);
    add_tag(TAG_AUDIO, 3, 32'd4, 8'hAF, PKT_NALU, 24'h0, -1);
    add_tag(TAG_VIDEO, 8, 32'd5, 8'h27, PKT_NALU, 24'hFF_FFFE, -1);

    while (stim.size() < 700) begin
      p = $urandom_range(0, 99);
      flags = 8'($urandom);
      if (p < 75) flags = flags | 8'h05;
      else if (p < 85) flags = flags & 8'hFA;
      add_file_header(8'($urandom), flags, $urandom_range(0, 99) < 92,
                      $urandom_range(0, 99) < 30);
      num_random_files++;
      ntags = $urandom_range(1, 10);
      for (t = 0; t < ntags; t++) begin
        if (stim.size() >= 700 || add_random_tag()) break;
      end
    end
  endfunction

  task automatic send_byte(flv_byte_t item);
    in_valid <= 1'b1;
    file_byte <= item.b;
    file_start <= item.s;
    do @(posedge clk); while (!in_ready);
  endtask

  initial begin
    int idle_pct;
    int i;
    build_stimulus();
    cycle_limit = 40 * stim.size() + 5000;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    idle_pct = 0;
    for (i = 0; i < stim.size(); i++) begin
      if (i % 64 == 0) begin
        case ($urandom_range(0, 2))
          0: idle_pct = 0;
          1: idle_pct = 10;
          default: idle_pct = 35;
        endcase
      end
      calm = (i >= stim.size() - CALM_TAIL);
      if (!calm && $urandom_range(0, 99) < idle_pct) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
      send_byte(stim[i]);
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_records.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Sent %0d bytes in %0d files (%0d random), %0d records checked.",
             stim.size(), num_files, num_random_files, sb.checked);
    $display("Records by kind: media %0d, config %0d, header %0d, short %0d.",
             sb.kind_seen[KIND_MEDIA], sb.kind_seen[KIND_CONFIG],
             sb.kind_seen[KIND_HEADER], sb.kind_seen[KIND_SHORT]);
    if (sb.errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/flvd_pkg.sv
rtl/flvd_parser.sv
rtl/flvd_scale.sv
rtl/flv_tag_demux_core.sv
verif/flv_tag_demux_core_tb.sv
